[rtl/core/ica_pkg.sv]
// Shared types and codes for the integer calculator ALU
`default_nettype none
package ica_pkg;

   localparam int MODE_W  = 3;
   localparam int FIELD_W = 32;

   typedef logic [MODE_W-1:0]         mode_type;
   typedef logic signed [FIELD_W-1:0] field_type;

   // operation codes; the two codes above factorial give zero results
   localparam mode_type MODE_ADD  = 3'd0;
   localparam mode_type MODE_SUB  = 3'd1;
   localparam mode_type MODE_MUL  = 3'd2;
   localparam mode_type MODE_DIV  = 3'd3;
   localparam mode_type MODE_POW  = 3'd4;
   localparam mode_type MODE_FACT = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_DIV_END,
      ST_POW,
      ST_FACT,
      ST_DONE
   } state_type;

   // where a finished shift-add product is written back
   typedef enum logic [1:0] {
      DST_RESULT,
      DST_ACC,
      DST_BASE
   } mul_dst_type;

   // control of the shared adder
   typedef struct packed {
      logic sub;
   } addsub_ctrl_type;

endpackage
`default_nettype wire

[rtl/core/ica_if.sv]
// Valid/ready channel interfaces for request and response items
`default_nettype none
interface ica_req_if;
   import ica_pkg::*;
   logic      valid;
   logic      ready;
   mode_type  mode;
   field_type operand_a;
   field_type operand_b;
   modport source (output valid, mode, operand_a, operand_b, input ready);
   modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface ica_rsp_if;
   import ica_pkg::*;
   logic      valid;
   logic      ready;
   field_type result;
   field_type remainder_out;
   logic      divide_by_zero;
   modport source (output valid, result, remainder_out, divide_by_zero, input ready);
   modport sink   (input valid, result, remainder_out, divide_by_zero, output ready);
endinterface
`default_nettype wire

[rtl/core/integer_calculator_alu.sv]
// Integer calculator ALU: add, sub, mul, divide, power and factorial on one shared adder.
// One item is taken when the block is idle and its result lands in an output register,
// so the next item can be taken while that result waits. The iterative steps run on one shared
// DATA_WIDTH-bit adder, and add and subtract use it too: a shift-add multiply runs until no
// multiplier bits remain, divide is restoring on magnitudes (a zero divisor skips it), power
// squares once per exponent bit below the top set bit and multiplies once per set bit, and
// factorial takes one short multiply per factor and stops past n or once the product wraps
// to zero. Operands are the low DATA_WIDTH bits of each field, sign extended when wider;
// results are sign extended from DATA_WIDTH bits into the 32-bit fields.
`default_nettype none
module integer_calculator_alu #(
   parameter int DATA_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   ica_req_if.sink   req_if,
   ica_rsp_if.source rsp_if
);
   import ica_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);

   state_type       state_ff, state_in;
   mode_type        mode_ff, mode_in;
   logic [W-1:0]    a_ff, a_in;         // operand a, base, dividend/quotient
   logic [W-1:0]    b_ff, b_in;         // operand b, exponent, divisor
   logic [W-1:0]    acc_ff, acc_in;     // power/factorial product, partial remainder
   logic [W-1:0]    fi_ff, fi_in;       // factorial multiplier
   logic [W-1:0]    mc_ff, mc_in;       // multiplicand
   logic [W-1:0]    mp_ff, mp_in;       // multiplier
   logic [W-1:0]    prod_ff, prod_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   mul_dst_type     dst_ff, dst_in;
   logic            neg_q_ff, neg_q_in;
   logic            neg_r_ff, neg_r_in;
   logic [W-1:0]    res_ff, res_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic            dz_ff, dz_in;
   logic [W-1:0]    res_out_ff, res_out_in;
   logic [W-1:0]    rem_out_ff, rem_out_in;
   logic            dz_out_ff, dz_out_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [W-1:0]    add_x;
   logic [W-1:0]    add_y;
   addsub_ctrl_type add_ctrl;
   logic [W-1:0]    add_sum;
   logic            add_carry;
   logic [W-1:0]    one_w;

   assign one_w = W'(1);

   ica_addsub #(.WIDTH(W)) u_addsub (
      .x     (add_x),
      .y     (add_y),
      .ctrl  (add_ctrl),
      .sum   (add_sum),
      .carry (add_carry)
   );

   // adder operand selection per sequencer step
   always_comb begin
      add_x        = a_ff;
      add_y        = b_ff;
      add_ctrl.sub = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            add_ctrl.sub = (mode_ff == MODE_SUB);
         end
         ST_MUL: begin
            add_x = prod_ff;
            add_y = mc_ff;
         end
         ST_DIV: begin
            add_x        = {acc_ff[W-2:0], a_ff[W-1]};
            add_y        = b_ff;
            add_ctrl.sub = 1'b1;
         end
         ST_FACT: begin
            add_x = fi_ff;
            add_y = one_w;
         end
         default: begin
            add_ctrl.sub = 1'b0;
         end
      endcase
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      fi_in        = fi_ff;
      mc_in        = mc_ff;
      mp_in        = mp_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      dst_in       = dst_ff;
      neg_q_in     = neg_q_ff;
      neg_r_in     = neg_r_ff;
      res_in       = res_ff;
      rem_in       = rem_ff;
      dz_in        = dz_ff;
      res_out_in   = res_out_ff;
      rem_out_in   = rem_out_ff;
      dz_out_in    = dz_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               mode_in  = req_if.mode;
               a_in     = W'(req_if.operand_a);
               b_in     = W'(req_if.operand_b);
               state_in = ST_LOAD;
            end
         end

         ST_LOAD: begin
            rem_in   = '0;
            dz_in    = 1'b0;
            res_in   = '0;
            state_in = ST_DONE;
            case (mode_ff)
               MODE_ADD, MODE_SUB: begin
                  res_in = add_sum;
               end
               MODE_MUL: begin
                  mc_in    = a_ff;
                  mp_in    = b_ff;
                  prod_in  = '0;
                  dst_in   = DST_RESULT;
                  state_in = ST_MUL;
               end
               MODE_DIV: begin
                  if (b_ff == '0) begin
                     dz_in = 1'b1;
                  end else begin
                     a_in     = a_ff[W-1] ? (~a_ff + one_w) : a_ff;
                     b_in     = b_ff[W-1] ? (~b_ff + one_w) : b_ff;
                     acc_in   = '0;
                     cnt_in   = CW'(W);
                     neg_q_in = a_ff[W-1] ^ b_ff[W-1];
                     neg_r_in = a_ff[W-1];
                     state_in = ST_DIV;
                  end
               end
               MODE_POW: begin
                  if (b_ff[W-1]) begin
                     res_in = one_w;
                  end else begin
                     acc_in   = one_w;
                     state_in = ST_POW;
                  end
               end
               MODE_FACT: begin
                  if (a_ff[W-1]) begin
                     res_in = one_w;
                  end else begin
                     acc_in   = one_w;
                     fi_in    = one_w;
                     state_in = ST_FACT;
                  end
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end

         // shift-add multiply, ends when no multiplier bits remain
         ST_MUL: begin
            if (mp_ff == '0) begin
               case (dst_ff)
                  DST_RESULT: begin
                     res_in   = prod_ff;
                     state_in = ST_DONE;
                  end
                  DST_ACC: begin
                     acc_in   = prod_ff;
                     state_in = (mode_ff == MODE_POW) ? ST_POW : ST_FACT;
                  end
                  DST_BASE: begin
                     a_in     = prod_ff;
                     state_in = ST_POW;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end else begin
               if (mp_ff[0]) begin
                  prod_in = add_sum;
               end
               mc_in = {mc_ff[W-2:0], 1'b0};
               mp_in = {1'b0, mp_ff[W-1:1]};
            end
         end

         // restoring divide on magnitudes, one quotient bit a cycle
         ST_DIV: begin
            acc_in = add_carry ? add_sum : add_x;
            a_in   = {a_ff[W-2:0], add_carry};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ST_DIV_END;
            end
         end

         ST_DIV_END: begin
            res_in   = neg_q_ff ? (~a_ff + one_w) : a_ff;
            rem_in   = neg_r_ff ? (~acc_ff + one_w) : acc_ff;
            state_in = ST_DONE;
         end

         // square and multiply, exponent consumed from its low end
         ST_POW: begin
            prod_in = '0;
            if (b_ff == '0) begin
               res_in   = acc_ff;
               state_in = ST_DONE;
            end else if (b_ff[0]) begin
               mc_in    = acc_ff;
               mp_in    = a_ff;
               dst_in   = DST_ACC;
               b_in     = {b_ff[W-1:1], 1'b0};
               state_in = ST_MUL;
            end else begin
               mc_in    = a_ff;
               mp_in    = a_ff;
               dst_in   = DST_BASE;
               b_in     = {1'b0, b_ff[W-1:1]};
               state_in = ST_MUL;
            end
         end

         // running product, stops past n or once it has wrapped to zero
         ST_FACT: begin
            if ((fi_ff <= a_ff) && (acc_ff != '0)) begin
               mc_in    = acc_ff;
               mp_in    = fi_ff;
               prod_in  = '0;
               dst_in   = DST_ACC;
               fi_in    = add_sum;
               state_in = ST_MUL;
            end else begin
               res_in   = acc_ff;
               state_in = ST_DONE;
            end
         end

         // hand over to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               res_out_in   = res_ff;
               rem_out_in   = rem_ff;
               dz_out_in    = dz_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      acc_ff     <= acc_in;
      fi_ff      <= fi_in;
      mc_ff      <= mc_in;
      mp_ff      <= mp_in;
      prod_ff    <= prod_in;
      cnt_ff     <= cnt_in;
      dst_ff     <= dst_in;
      neg_q_ff   <= neg_q_in;
      neg_r_ff   <= neg_r_in;
      res_ff     <= res_in;
      rem_ff     <= rem_in;
      dz_ff      <= dz_in;
      res_out_ff <= res_out_in;
      rem_out_ff <= rem_out_in;
      dz_out_ff  <= dz_out_in;
   end

   // ports
   assign req_if.ready          = (state_ff == ST_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.result         = FIELD_W'($signed(res_out_ff));
   assign rsp_if.remainder_out  = FIELD_W'($signed(rem_out_ff));
   assign rsp_if.divide_by_zero = dz_out_ff;

endmodule
`default_nettype wire

[rtl/core/ica_addsub.sv]
// Shared adder/subtractor with carry out, used by every iterative step
`default_nettype none
module ica_addsub #(
   parameter int WIDTH = 32
) (
   input  wire logic [WIDTH-1:0]            x,
   input  wire logic [WIDTH-1:0]            y,
   input  wire ica_pkg::addsub_ctrl_type    ctrl,
   output logic      [WIDTH-1:0]            sum,
   output logic                             carry
);
   import ica_pkg::*;

   logic [WIDTH:0] full;

   // x + y, or x - y as x + ~y + 1; carry set means no borrow
   assign full  = {1'b0, x} + {1'b0, (ctrl.sub ? ~y : y)} + {{WIDTH{1'b0}}, ctrl.sub};
   assign sum   = full[WIDTH-1:0];
   assign carry = full[WIDTH];

endmodule
`default_nettype wire

[rtl/core/ica_checker.sv]
// Port-level checks for the integer calculator ALU, bound to the top level
`default_nettype none
module ica_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire ica_pkg::field_type  rsp_result,
   input wire ica_pkg::field_type  rsp_remainder,
   input wire logic                rsp_dz
);
   import ica_pkg::*;

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) && $stable(rsp_remainder)
         && $stable(rsp_dz))
      else $error("response item changed while stalled");

   // a zero divisor yields zero quotient and remainder
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dz |-> (rsp_result == '0) && (rsp_remainder == '0))
      else $error("divide by zero with non-zero results");

   // the block is busy right after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an item was taken");

   // nothing is offered straight out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind integer_calculator_alu ica_checker u_ica_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_result    (rsp_if.result),
   .rsp_remainder (rsp_if.remainder_out),
   .rsp_dz        (rsp_if.divide_by_zero)
);
`default_nettype wire

[bench/integer_calculator_alu_tb.sv]
// Self-checking testbench for the integer calculator ALU: directed table, then random items
`default_nettype none
module integer_calculator_alu_tb;
   import ica_pkg::*;

   // codes above factorial carry no operation
   localparam mode_type MODE_RSVD_A = 3'd6;
   localparam mode_type MODE_RSVD_B = 3'd7;

   localparam field_type F_MIN = 32'sh8000_0000;
   localparam field_type F_MAX = 32'sh7FFF_FFFF;

   localparam int  N_RANDOM  = 850;
   localparam int  IDLE_PCT  = 34;
   localparam int  CALM_FROM = 330;   // accepted-item window with no idling on either side
   localparam int  CALM_TO   = 480;
   localparam int  DRAIN     = 80;
   localparam longint LIMIT  = 8_000_000;

   typedef struct packed {
      field_type result;
      field_type remainder;
      logic      div_zero;
   } calc_answer_t;

   typedef struct packed {
      mode_type     mode;
      field_type    a;
      field_type    b;
      logic         known;   // answer typed into the table
      calc_answer_t ans;
   } calc_req_t;

   localparam calc_answer_t NO_ANS   = '0;
   localparam calc_answer_t ANS_ZERO = '0;
   localparam calc_answer_t ANS_ONE  = '{32'sd1, 32'sd0, 1'b0};
   localparam calc_answer_t ANS_DZ   = '{32'sd0, 32'sd0, 1'b1};

   localparam int N_DIRECTED = 24;
   localparam calc_req_t DIRECTED [0:N_DIRECTED-1] = '{
      '{MODE_ADD,    F_MAX,    32'sd1,   1'b1, '{F_MIN, 32'sd0, 1'b0}},
      '{MODE_ADD,    F_MIN,    F_MIN,    1'b1, ANS_ZERO},
      '{MODE_SUB,    F_MIN,    32'sd1,   1'b1, '{F_MAX, 32'sd0, 1'b0}},
      '{MODE_SUB,    32'sd0,   F_MIN,    1'b1, '{F_MIN, 32'sd0, 1'b0}},
      '{MODE_MUL,    -32'sd1,  -32'sd1,  1'b1, ANS_ONE},
      '{MODE_MUL,    F_MAX,    F_MAX,    1'b0, NO_ANS},
      '{MODE_MUL,    F_MIN,    -32'sd1,  1'b1, '{F_MIN, 32'sd0, 1'b0}},
      '{MODE_DIV,    F_MIN,    -32'sd1,  1'b1, '{F_MIN, 32'sd0, 1'b0}},
      '{MODE_DIV,    32'sd7,   32'sd0,   1'b1, ANS_DZ},
      '{MODE_DIV,    F_MIN,    32'sd0,   1'b1, ANS_DZ},
      '{MODE_DIV,    -32'sd7,  32'sd2,   1'b1, '{-32'sd3, -32'sd1, 1'b0}},
      '{MODE_DIV,    32'sd7,   -32'sd2,  1'b1, '{-32'sd3, 32'sd1, 1'b0}},
      '{MODE_DIV,    F_MAX,    F_MIN,    1'b1, '{32'sd0, F_MAX, 1'b0}},
      '{MODE_POW,    32'sd3,   32'sd0,   1'b1, ANS_ONE},
      '{MODE_POW,    32'sd5,   -32'sd1,  1'b1, ANS_ONE},
      '{MODE_POW,    32'sd2,   32'sd31,  1'b1, '{F_MIN, 32'sd0, 1'b0}},
      '{MODE_POW,    32'sd2,   32'sd32,  1'b1, ANS_ZERO},
      '{MODE_POW,    -32'sd1,  F_MAX,    1'b1, '{-32'sd1, 32'sd0, 1'b0}},
      '{MODE_POW,    32'sd3,   F_MAX,    1'b0, NO_ANS},
      '{MODE_FACT,   -32'sd5,  F_MAX,    1'b1, ANS_ONE},
      '{MODE_FACT,   32'sd12,  32'sd0,   1'b1, '{32'sd479001600, 32'sd0, 1'b0}},
      '{MODE_FACT,   32'sd33,  F_MIN,    1'b0, NO_ANS},
      '{MODE_FACT,   F_MAX,    32'sd0,   1'b1, ANS_ZERO},
      '{MODE_RSVD_B, -32'sd1,  -32'sd1,  1'b1, ANS_ZERO}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   ica_req_if req_ch ();
   ica_rsp_if rsp_ch ();

   integer_calculator_alu #(.DATA_WIDTH(32)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #2 clock = ~clock;

   calc_req_t    work_list [$];
   calc_answer_t answers_due [$];
   int           n_taken   = 0;
   int           n_checked = 0;
   int           n_div_zero = 0;
   int           fail_count = 0;
   int           mode_seen [0:7];
   longint       cycles = 0;

   // arithmetic of one item, everything wrapped to 32 bits
   function automatic calc_answer_t compute_answer(calc_req_t r);
      calc_answer_t ans;
      logic [31:0]  a, b, ma, mb, q, rm, acc, base, expo;
      int unsigned  k;
      ans = '0;
      a = r.a;
      b = r.b;
      case (r.mode)
         MODE_ADD: ans.result = a + b;
         MODE_SUB: ans.result = a - b;
         MODE_MUL: ans.result = a * b;
         MODE_DIV: begin
            if (b == 32'd0) begin
               ans.div_zero = 1'b1;
            end else begin
               ma = a[31] ? -a : a;
               mb = b[31] ? -b : b;
               q  = ma / mb;
               rm = ma % mb;
               ans.result    = (a[31] ^ b[31]) ? -q : q;
               ans.remainder = a[31] ? -rm : rm;
            end
         end
         MODE_POW: begin
            acc = 32'd1;
            if (!b[31]) begin
               base = a;
               expo = b;
               while (expo != 32'd0) begin
                  if (expo[0]) acc = acc * base;
                  base = base * base;
                  expo = expo >> 1;
               end
            end
            ans.result = acc;
         end
         MODE_FACT: begin
            acc = 32'd1;
            if (!a[31]) begin
               // once the product wraps to zero it stays there
               for (k = 1; k <= a && acc != 32'd0; k++) acc = acc * k;
            end
            ans.result = acc;
         end
         default: ans = '0;
      endcase
      return ans;
   endfunction

   function automatic field_type pick_operand();
      field_type v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: v = $urandom;
         5: v = field_type'($urandom_range(0, 32)) - 32'sd16;
         6: v = F_MIN;
         7: v = F_MAX;
         8: v = field_type'($urandom_range(0, 2)) - 32'sd1;
         default: begin
            v = 32'sd1 <<< $urandom_range(0, 31);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   // random item; exponents are mostly short so that power stays quick
   function automatic calc_req_t random_req();
      calc_req_t r;
      r = '0;
      r.mode = mode_type'($urandom_range(0, 7));
      r.a = pick_operand();
      r.b = pick_operand();
      case (r.mode)
         MODE_DIV: begin
            case ($urandom_range(0, 9))
               0: r.b = 32'sd0;
               1: begin
                  r.a = F_MIN;
                  r.b = -32'sd1;
               end
               default: ;
            endcase
         end
         MODE_POW: begin
            case ($urandom_range(0, 9))
               0: r.b = $urandom;
               1: r.b = -field_type'($urandom_range(0, 5));
               default: r.b = $urandom_range(0, 20);
            endcase
         end
         MODE_FACT: if ($urandom_range(0, 3) != 0) r.a = $urandom_range(0, 40);
         default: ;
      endcase
      return r;
   endfunction

   // idle decision shared by both sides; none inside the calm window
   function automatic bit take_break();
      if (n_taken >= CALM_FROM && n_taken < CALM_TO) return 1'b0;
      return $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   // response side readiness, changed at the falling edge
   always @(negedge clock) begin
      rsp_ch.ready <= !take_break();
   end

   // monitor: record expectations on accepted requests, check accepted results
   always @(posedge clock) begin
      calc_req_t    r;
      calc_answer_t want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            r = work_list[n_taken];
            want = r.known ? r.ans : compute_answer(r);
            answers_due.push_back(want);
            mode_seen[req_ch.mode]++;
            n_taken++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (answers_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result %h rem %h dz %b with nothing outstanding",
                           rsp_ch.result, rsp_ch.remainder_out, rsp_ch.divide_by_zero);
            end else begin
               want = answers_due.pop_front();
               if (rsp_ch.result !== want.result || rsp_ch.remainder_out !== want.remainder
                   || rsp_ch.divide_by_zero !== want.div_zero) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result %0d mismatch: expected %h/%h/%b, got %h/%h/%b",
                              n_checked, want.result, want.remainder, want.div_zero,
                              rsp_ch.result, rsp_ch.remainder_out, rsp_ch.divide_by_zero);
               end
               if (rsp_ch.divide_by_zero === 1'b1) n_div_zero++;
               n_checked++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  answers_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // request side: build the item list, reset, then offer items at the falling edge
   initial begin
      int idx;
      foreach (mode_seen[m]) mode_seen[m] = 0;
      req_ch.valid     = 1'b0;
      req_ch.mode      = MODE_ADD;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      rsp_ch.ready     = 1'b0;
      foreach (DIRECTED[i]) work_list.push_back(DIRECTED[i]);
      repeat (N_RANDOM) work_list.push_back(random_req());

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idx = 0;
      while (idx < work_list.size()) begin
         if (take_break()) begin
            req_ch.valid     <= 1'b0;
            req_ch.mode      <= mode_type'($urandom_range(0, 7));
            req_ch.operand_a <= $urandom;
            req_ch.operand_b <= $urandom;
            @(negedge clock);
         end else begin
            req_ch.valid     <= 1'b1;
            req_ch.mode      <= work_list[idx].mode;
            req_ch.operand_a <= work_list[idx].a;
            req_ch.operand_b <= work_list[idx].b;
            @(posedge clock);
            while (!req_ch.ready) @(posedge clock);
            idx++;
            @(negedge clock);
         end
      end
      req_ch.valid <= 1'b0;

      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("Ran %0d items (%0d from the table), %0d results checked, %0d zero divisors",
               n_taken, N_DIRECTED, n_checked, n_div_zero);
      $display("By mode: add %0d sub %0d mul %0d div %0d pow %0d fact %0d spare %0d",
               mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4],
               mode_seen[5], mode_seen[6] + mode_seen[7]);
      if (fail_count == 0 && answers_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d failures", fail_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
